[sv/elu_pkg.sv]
// Shared types, constants and fp16 multiply helpers for the fp16 ELU pipeline.
package elu_pkg;

    // fp16 constants
    localparam logic [15:0] INV_LN2_HALF = 16'h3dc6;
    localparam logic [15:0] QNAN_HALF    = 16'h7e00;
    localparam logic [15:0] ALPHA_RESET  = 16'h3c00;

    // register map: paddr[2] selects the word
    localparam logic REG_ALPHA = 1'b0;

    // Q1.31 / Q0.31 fixed-point constants for 2^f
    localparam logic [31:0] Q31_ONE        = 32'h8000_0000;
    localparam logic [31:0] Q31_HALF       = 32'h4000_0000;
    localparam logic [31:0] Q31_SIXTH      = 32'h1555_5555;
    localparam logic [31:0] Q31_24TH       = 32'h0555_5555;
    localparam logic [31:0] Q31_120TH      = 32'h0111_1111;
    localparam logic [31:0] EXP2_HALF      = 32'hb504_f334;  // 2^(1/2)
    localparam logic [31:0] EXP2_QUARTER   = 32'h9837_f052;  // 2^(1/4)
    localparam logic [31:0] EXP2_EIGHTH    = 32'h8b95_c1e4;  // 2^(1/8)
    localparam logic [31:0] EXP2_SIXTEENTH = 32'h85aa_c368;  // 2^(1/16)
    localparam logic [31:0] LN2_Q32        = 32'hb172_17f8;  // ln2 * 2^32

    // fp16 product before rounding: value = prod * 2^sexp
    typedef struct packed {
        logic               sgn;
        logic               is_nan;
        logic               is_inf;
        logic [21:0]        prod;
        logic signed [7:0]  sexp;
    } t_mul_pre;

    // Unpack two fp16 operands and form the exact significand product
    function automatic t_mul_pre fp_mul_pre(input logic [15:0] a, input logic [15:0] b);
        t_mul_pre   res;
        logic       a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
        logic [10:0] sa, sb;
        logic [4:0] ea, eb;
        a_nan  = (a[14:10] == 5'h1f) && (a[9:0] != 10'h0);
        b_nan  = (b[14:10] == 5'h1f) && (b[9:0] != 10'h0);
        a_inf  = (a[14:10] == 5'h1f) && (a[9:0] == 10'h0);
        b_inf  = (b[14:10] == 5'h1f) && (b[9:0] == 10'h0);
        a_zero = (a[14:0] == 15'h0);
        b_zero = (b[14:0] == 15'h0);
        ea     = (a[14:10] == 5'h0) ? 5'd1 : a[14:10];
        eb     = (b[14:10] == 5'h0) ? 5'd1 : b[14:10];
        sa     = {(a[14:10] != 5'h0), a[9:0]};
        sb     = {(b[14:10] != 5'h0), b[9:0]};
        res.sgn    = a[15] ^ b[15];
        res.is_nan = a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
        res.is_inf = (a_inf | b_inf) & ~res.is_nan;
        res.prod   = {11'h0, sa} * {11'h0, sb};
        res.sexp   = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 8'sd50;
        return res;
    endfunction

    // Normalize and round an exact product to fp16, nearest-even, subnormals kept
    function automatic logic [15:0] fp_mul_round(input t_mul_pre pre);
        logic [4:0]        k;
        logic signed [8:0] e_unb;
        logic signed [8:0] sub_sh;
        logic              normal;
        logic [5:0]        total;
        logic [63:0]       w, q, mask, half, rem;
        logic              up;
        logic [5:0]        ebias;
        logic [16:0]       r;
        logic [15:0]       res;
        k = 5'd0;
        for (int i = 0; i < 22; i++) begin
            if (pre.prod[i]) k = 5'(i);
        end
        e_unb  = $signed({4'b0000, k}) + $signed({pre.sexp[7], pre.sexp});
        normal = (e_unb >= -9'sd14);
        sub_sh = -9'sd14 - $signed({pre.sexp[7], pre.sexp});
        total  = normal ? {1'b0, k} : sub_sh[5:0];
        w      = {32'h0, pre.prod, 10'h0};
        q      = w >> total;
        mask   = (64'd1 << total) - 64'd1;
        rem    = w & mask;
        half   = (total == 6'd0) ? 64'd0 : (64'd1 << (total - 6'd1));
        up     = (total != 6'd0) && ((rem > half) || ((rem == half) && q[0]));
        q      = q + {63'h0, up};
        ebias  = 6'(e_unb + 9'sd14);
        r      = normal ? ({1'b0, ebias, 10'h0} + {5'h0, q[11:0]}) : {5'h0, q[11:0]};
        if (pre.is_nan) begin
            res = QNAN_HALF;
        end else if (pre.is_inf) begin
            res = {pre.sgn, 15'h7c00};
        end else if (pre.prod == 22'h0) begin
            res = {pre.sgn, 15'h0};
        end else if (r >= 17'h7c00) begin
            res = {pre.sgn, 15'h7c00};
        end else begin
            res = {pre.sgn, r[14:0]};
        end
        return res;
    endfunction

    // Q1.31 times Q1.31, product known to stay below 2.0
    function automatic logic [31:0] q31_mul(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = {32'h0, a} * {32'h0, b};
        return p[62:31];
    endfunction

endpackage

[sv/fp16_elu_activation.sv]
// Top level: fixed-latency pipelined fp16 ELU with an APB register for alpha.
//
// One fp16 value enters per clock while the output is not stalled. Its ELU
// result passes through 16 register stages to the output, and throughput is
// one beat per cycle unless stalled. The path is: fp16 multiply by 1/ln2, a
// fixed-point 2^t (top four fraction bits by constant factors, the rest by a
// fifth-order series, at most one 32x32 multiply deep per stage), rounding of
// 2^t and of 2^t - 1 to fp16, then the fp16 multiply by alpha. A stall at the
// output freezes the whole pipeline; the output register holds the waiting
// result while upstream stages keep their data, so nothing is lost or repeated.
// alpha sits at byte address 0 and must only be written while the pipe is empty.
module fp16_elu_activation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_x_half,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_y_half,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NSTG = 16;

    logic                 w_en;
    logic [15:0]          r_alpha;
    logic [NSTG-1:0]      r_vld;
    logic [15:0]          r_x     [0:14];
    elu_pkg::t_mul_pre    r_pre_t;
    logic [15:0]          r_t;
    logic [23:0]          r_f;
    logic [5:0]           r_nexp  [2:10];
    logic                 r_zero  [2:10];
    logic [26:0]          r_yq    [3:7];
    logic [31:0]          r_m     [3:8];
    logic [2:0]           r_fb;
    logic [1:0]           r_fb4;
    logic                 r_fb5;
    logic [31:0]          r_h     [4:8];
    logic [31:0]          r_mant;
    logic [11:0]          r_qe;
    logic                 r_norm;
    logic [24:0]          r_d;
    logic [15:0]          r_dm;
    elu_pkg::t_mul_pre    r_pre_p;
    logic [15:0]          r_p;
    logic [15:0]          r_y;

    logic [15:0]          n_lo;
    elu_pkg::t_mul_pre    n_pre_t;
    logic [15:0]          n_t;
    logic [4:0]           n_te, n_tsh;
    logic [10:0]          n_tm;
    logic [28:0]          n_amag;
    logic [29:0]          n_tn;
    logic                 n_zero;
    logic [51:0]          n_yprod;
    logic [26:0]          n_yq;
    logic [31:0]          n_m3;
    logic [31:0]          n_h1, n_h2, n_h3, n_h4, n_h5;
    logic [31:0]          n_m4, n_m5, n_m6;
    logic [31:0]          n_mant;
    logic                 n_norm;
    logic [5:0]           n_esh;
    logic [32:0]          n_mw, n_eq, n_emask, n_erem, n_ehalf;
    logic                 n_eup;
    logic [11:0]          n_qe;
    logic [3:0]           n_lsh;
    logic [25:0]          n_e;
    logic [24:0]          n_d;
    logic [4:0]           n_dk;
    logic [3:0]           n_dsh;
    logic [24:0]          n_dq, n_dmask, n_drem, n_dhalf;
    logic                 n_dup;
    logic [15:0]          n_dr;
    logic [15:0]          n_dm;
    elu_pkg::t_mul_pre    n_pre_p;
    logic [15:0]          n_p;
    logic                 n_xpos;
    logic [15:0]          n_y;

    // pipeline advances unless the output beat is held
    assign w_en    = !(r_vld[NSTG-1] && i_stall);
    assign o_stall = r_vld[NSTG-1] && i_stall;
    assign o_valid = r_vld[NSTG-1];
    assign o_y_half = r_y;

    // register port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == elu_pkg::REG_ALPHA) ? {16'h0, r_alpha} : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= elu_pkg::ALPHA_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == elu_pkg::REG_ALPHA)) begin
            r_alpha <= pwdata[15:0];
        end
    end

    // stage 0: min(x,0) times 1/ln2, exact product
    always_comb begin
        n_lo    = (i_x_half[15] && (i_x_half[14:0] != 15'h0) &&
                   !((i_x_half[14:10] == 5'h1f) && (i_x_half[9:0] != 10'h0))) ? i_x_half : 16'h0;
        n_pre_t = elu_pkg::fp_mul_pre(n_lo, elu_pkg::INV_LN2_HALF);
    end

    // stage 1: round t
    assign n_t = elu_pkg::fp_mul_round(r_pre_t);

    // stage 2: t as fixed point, split into floor and fraction
    always_comb begin
        n_te   = r_t[14:10];
        n_tm   = {(n_te != 5'h0), r_t[9:0]};
        n_tsh  = ((n_te == 5'h0) ? 5'd1 : n_te) - 5'd1;
        n_amag = {18'h0, n_tm} << n_tsh;
        n_zero = (n_te > 5'd19) || (n_amag >= 29'(25 << 24));
        n_tn   = 30'h0 - {1'b0, n_amag};
    end

    // stage 3: series argument and top fraction bit
    always_comb begin
        n_yprod = {32'h0, r_f[19:0]} * {20'h0, elu_pkg::LN2_Q32};
        n_yq    = n_yprod[51:25];
        n_m3    = r_f[23] ? elu_pkg::EXP2_HALF : elu_pkg::Q31_ONE;
    end

    // stages 4..8: Horner series for exp(y), constant factors for bits 22..20
    always_comb begin
        n_h1 = elu_pkg::Q31_24TH  + elu_pkg::q31_mul({5'h0, r_yq[3]}, elu_pkg::Q31_120TH);
        n_h2 = elu_pkg::Q31_SIXTH + elu_pkg::q31_mul({5'h0, r_yq[4]}, r_h[4]);
        n_h3 = elu_pkg::Q31_HALF  + elu_pkg::q31_mul({5'h0, r_yq[5]}, r_h[5]);
        n_h4 = elu_pkg::Q31_ONE   + elu_pkg::q31_mul({5'h0, r_yq[6]}, r_h[6]);
        n_h5 = elu_pkg::Q31_ONE   + elu_pkg::q31_mul({5'h0, r_yq[7]}, r_h[7]);
        n_m4 = r_fb[2]  ? elu_pkg::q31_mul(r_m[3], elu_pkg::EXP2_QUARTER)   : r_m[3];
        n_m5 = r_fb4[1] ? elu_pkg::q31_mul(r_m[4], elu_pkg::EXP2_EIGHTH)    : r_m[4];
        n_m6 = r_fb5    ? elu_pkg::q31_mul(r_m[5], elu_pkg::EXP2_SIXTEENTH) : r_m[5];
    end

    // stage 9: 2^f in Q1.31
    assign n_mant = elu_pkg::q31_mul(r_m[8], r_h[8]);

    // stage 10: round 2^t to fp16 precision
    always_comb begin
        n_norm  = ($signed(r_nexp[9]) >= -6'sd14);
        n_esh   = n_norm ? 6'd21 : 6'(7'sd7 - $signed({r_nexp[9][5], r_nexp[9]}));
        n_mw    = {1'b0, r_mant};
        n_eq    = n_mw >> n_esh;
        n_emask = (33'd1 << n_esh) - 33'd1;
        n_erem  = n_mw & n_emask;
        n_ehalf = 33'd1 << (n_esh - 6'd1);
        n_eup   = (n_erem > n_ehalf) || ((n_erem == n_ehalf) && n_eq[0]);
        n_qe    = n_eq[11:0] + {11'h0, n_eup};
    end

    // stage 11: 1 - e in units of 2^-24
    always_comb begin
        n_lsh = 4'(r_nexp[10] + 6'd14);
        if (r_zero[10]) begin
            n_e = 26'h0;
        end else if (r_norm) begin
            n_e = {14'h0, r_qe} << n_lsh;
        end else begin
            n_e = {14'h0, r_qe};
        end
        n_d = 25'((26'd1 << 24) - n_e);
    end

    // stage 12: dm = -(1 - e) rounded to fp16
    always_comb begin
        n_dk = 5'd0;
        for (int i = 0; i < 25; i++) begin
            if (r_d[i]) n_dk = 5'(i);
        end
        n_dsh   = 4'(n_dk - 5'd10);
        n_dq    = r_d >> n_dsh;
        n_dmask = (25'd1 << n_dsh) - 25'd1;
        n_drem  = r_d & n_dmask;
        n_dhalf = (n_dsh == 4'd0) ? 25'd0 : (25'd1 << (n_dsh - 4'd1));
        n_dup   = (n_dsh != 4'd0) && ((n_drem > n_dhalf) || ((n_drem == n_dhalf) && n_dq[0]));
        n_dr    = {2'b00, n_dsh, 10'h0} + {4'h0, n_dq[11:0] + {11'h0, n_dup}};
        if (r_d == 25'h0) begin
            n_dm = 16'h0;
        end else if (n_dk >= 5'd10) begin
            n_dm = {1'b1, n_dr[14:0]};
        end else begin
            n_dm = {1'b1, 5'h0, r_d[9:0]};
        end
    end

    // stages 13..14: alpha times dm
    assign n_pre_p = elu_pkg::fp_mul_pre(r_alpha, r_dm);
    assign n_p     = elu_pkg::fp_mul_round(r_pre_p);

    // stage 15: add max(x,0)
    always_comb begin
        n_xpos = !r_x[14][15] && (r_x[14][14:0] != 15'h0) &&
                 !((r_x[14][14:10] == 5'h1f) && (r_x[14][9:0] != 10'h0));
        if (r_p == elu_pkg::QNAN_HALF) begin
            n_y = elu_pkg::QNAN_HALF;
        end else if (n_xpos) begin
            n_y = r_x[14];
        end else if (r_p == 16'h8000) begin
            n_y = 16'h0;
        end else begin
            n_y = r_p;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x[0] <= i_x_half;
            for (int s = 1; s < 15; s++) begin
                r_x[s] <= r_x[s-1];
            end
            r_pre_t <= n_pre_t;
            r_t     <= n_t;
            r_f          <= n_tn[23:0];
            r_nexp[2]    <= n_tn[29:24];
            r_zero[2]    <= n_zero;
            for (int s = 3; s < 11; s++) begin
                r_nexp[s] <= r_nexp[s-1];
                r_zero[s] <= r_zero[s-1];
            end
            r_yq[3] <= n_yq;
            for (int s = 4; s < 8; s++) begin
                r_yq[s] <= r_yq[s-1];
            end
            r_fb    <= r_f[22:20];
            r_fb4   <= r_fb[1:0];
            r_fb5   <= r_fb4[0];
            r_m[3]  <= n_m3;
            r_m[4]  <= n_m4;
            r_m[5]  <= n_m5;
            r_m[6]  <= n_m6;
            r_m[7]  <= r_m[6];
            r_m[8]  <= r_m[7];
            r_h[4]  <= n_h1;
            r_h[5]  <= n_h2;
            r_h[6]  <= n_h3;
            r_h[7]  <= n_h4;
            r_h[8]  <= n_h5;
            r_mant  <= n_mant;
            r_qe    <= n_qe;
            r_norm  <= n_norm;
            r_d     <= n_d;
            r_dm    <= n_dm;
            r_pre_p <= n_pre_p;
            r_p     <= n_p;
            r_y     <= n_y;
        end
    end

    // checks on internal invariants
    a_dm_nonpos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[12] |-> (r_dm[15] || (r_dm == 16'h0)))
        else $error("dm is positive");

    a_d_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[11] |-> (r_d <= 25'(1 << 24)))
        else $error("1 - e out of range");

    a_mant_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[9] |-> r_mant[31])
        else $error("2^f mantissa not normalized");

    a_alpha_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && (paddr[2] == elu_pkg::REG_ALPHA))
        |=> (r_alpha == $past(pwdata[15:0])))
        else $error("alpha write lost");

endmodule

[sim/tb.sv]
// Self-checking testbench for the pipelined fp16 ELU unit with APB alpha register.
module tb;

    localparam int PIPE_DRAIN = 40;

    // Reference arithmetic and queue of expected ELU outputs
    class elu_scoreboard;
        logic [15:0] alpha;
        logic [15:0] y_pending[$];
        int          errors;

        function new();
            alpha  = elu_pkg::ALPHA_RESET;
            errors = 0;
        endfunction

        function real pow2(int k);
            logic [10:0] ex;
            ex = 11'(k + 1023);
            return $bitstoreal({1'b0, ex, 52'h0});
        endfunction

        function real half_val(logic [15:0] h);
            logic [63:0] b;
            real         v;
            if (h[14:10] == 5'h1f) begin
                b = (h[9:0] != 0) ? 64'h7ff8000000000000 : 64'h7ff0000000000000;
                b[63] = h[15];
                return $bitstoreal(b);
            end
            if (h[14:10] == 0)
                v = real'(h[9:0]) * pow2(-24);
            else
                v = real'({1'b1, h[9:0]}) * pow2(int'(h[14:10]) - 25);
            return h[15] ? -v : v;
        endfunction

        // Round a double to fp16, nearest-even, subnormals kept
        function logic [15:0] to_half(real d);
            logic [63:0] b, m, q, rem, hv, r;
            logic [15:0] s;
            int          e, sh;
            b = $realtobits(d);
            s = {b[63], 15'h0};
            e = int'(b[62:52]);
            m = {12'h0, b[51:0]};
            if (e == 'h7ff) return (m != 0) ? elu_pkg::QNAN_HALF : (s | 16'h7c00);
            if (e == 0) return s;
            e = e - 1023;
            if (e > 15) return s | 16'h7c00;
            m = m | (64'd1 << 52);
            sh = 42;
            if (e < -14) sh = 42 + (-14 - e);
            if (sh > 54) return s;
            q   = m >> sh;
            rem = m & ((64'd1 << sh) - 1);
            hv  = 64'd1 << (sh - 1);
            if (rem > hv || (rem == hv && q[0])) q = q + 1;
            if (e < -14) r = q;
            else r = (64'(e + 14) << 10) + q;
            if (r >= 64'h7c00) return s | 16'h7c00;
            return s | r[15:0];
        endfunction

        function logic [15:0] exp2_half(logic [15:0] tb_in);
            real t, f, y, term, sum;
            int  n;
            t = half_val(tb_in);
            if (t != t) return elu_pkg::QNAN_HALF;
            if (t >= 16.0) return 16'h7c00;
            if (t <= -25.0) return 16'h0000;
            n = int'($floor(t));
            f = t - real'(n);
            y = f * 0.6931471805599453;
            term = 1.0;
            sum  = 1.0;
            for (int k = 1; k <= 24; k++) begin
                term = term * y / real'(k);
                sum  = sum + term;
            end
            return to_half(sum * pow2(n));
        endfunction

        function logic [15:0] elu_of(logic [15:0] x);
            real         xd;
            logic [15:0] neg_part, pos_part, t, ex, dm, p;
            xd = half_val(x);
            neg_part = (xd < 0.0) ? x : 16'h0;
            pos_part = (xd > 0.0) ? x : 16'h0;
            t  = to_half(half_val(neg_part) * half_val(elu_pkg::INV_LN2_HALF));
            ex = exp2_half(t);
            dm = to_half(half_val(ex) - 1.0);
            p  = to_half(half_val(alpha) * half_val(dm));
            return to_half(half_val(pos_part) + half_val(p));
        endfunction

        function void note_x(logic [15:0] x);
            y_pending.push_back(elu_of(x));
        endfunction

        function void check_y(logic [15:0] y);
            logic [15:0] exp_y;
            if (y_pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected output beat y=%h", y);
                return;
            end
            exp_y = y_pending.pop_front();
            if (y !== exp_y) begin
                errors++;
                if (errors <= 10)
                    $display("y_half mismatch: expected %h got %h (alpha %h)",
                             exp_y, y, alpha);
            end
        endfunction
    endclass

    logic        i_clk, i_rst_n;
    logic        i_valid, o_stall, o_valid;
    logic        i_stall = 1'b0;
    logic [15:0] i_x_half, o_y_half;
    logic        psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;

    elu_scoreboard sb;
    int          stall_mode = 0;

    fp16_elu_activation uut (.*);

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Output side: stall patterns that change over the run
    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 1) == 0);
            default: i_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Output beat check
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_y(o_y_half);
    end

    task automatic send_x(logic [15:0] x);
        i_valid  <= 1'b1;
        i_x_half <= x;
        do @(posedge i_clk); while (o_stall);
        sb.note_x(x);
    endtask

    task automatic idle_gap();
        int gap;
        gap = $urandom_range(1, 6);
        i_valid <= 1'b0;
        repeat (gap) @(posedge i_clk);
    endtask

    // Send bursts of random length, each maybe preceded by a gap
    task automatic send_random(int count);
        int burst;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 20);
                if ($urandom_range(0, 2) != 0) idle_gap();
            end
            send_x(16'($urandom_range(0, 65535)));
            burst--;
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.y_pending.size() != 0) @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    task automatic write_alpha(logic [15:0] a);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {elu_pkg::REG_ALPHA, 2'b00};
        pwdata  <= {16'h0, a};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sb.alpha = a;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    logic [15:0] directed_x[] = '{16'h0000, 16'h8000, 16'h7c00, 16'hfc00, 16'h7e00,
                                  16'h7c01, 16'hfe00, 16'h0001, 16'h8001, 16'h03ff,
                                  16'h83ff, 16'h0400, 16'h8400, 16'h7bff, 16'hfbff,
                                  16'h3c00, 16'hbc00, 16'hc000, 16'hcc00, 16'hd240,
                                  16'hd700, 16'hb800, 16'h9400, 16'hffff};
    logic [15:0] alpha_set[] = '{16'h0000, 16'hffff, 16'h7c00, 16'h7bff, 16'h0001,
                                 16'h8000, 16'hbc00, 16'h3c00};

    initial begin
        sb         = new();
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_x_half   = 16'h0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = 3'h0;
        pwdata     = 32'h0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed values at reset alpha, back to back
        foreach (directed_x[k]) send_x(directed_x[k]);
        drain();

        // each alpha setting, including extremes, then a random one
        foreach (alpha_set[k]) begin
            write_alpha(alpha_set[k]);
            foreach (directed_x[j]) if (j % 3 == k % 3) send_x(directed_x[j]);
            send_random(130);
            drain();
        end
        write_alpha(16'($urandom_range(0, 65535)));
        send_random(150);
        drain();

        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog
    initial begin
        #5000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

[fp16_elu_activation.f]
sv/elu_pkg.sv
sv/fp16_elu_activation.sv
sim/tb.sv
